// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== hw/rtl/cpio_pkg.sv =====
// ---------------------------------------------------------------------------
// cpio_pkg
// types, constants and helper functions of the cpio newc archive walker
// ---------------------------------------------------------------------------
package cpio_pkg;

  // result kinds
  typedef enum logic [2:0] {
    K_PATH        = 3'd0,
    K_PATH_END    = 3'd1,
    K_DATA        = 3'd2,
    K_ENTRY_END   = 3'd3,
    K_ARCHIVE_END = 3'd4
  } kind_t;

  // walker phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_NAME   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // up to two results per byte; v1 implies v0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } step_res_t;

  typedef struct packed {
    logic room2;
    logic empty;
  } fifo_stat_t;

  localparam logic [6:0] HDR_LAST    = 7'd109;
  localparam logic [6:0] FSIZE_LAST  = 7'd61;
  localparam logic [6:0] NSIZE_LAST  = 7'd101;
  localparam logic [1:0] HDR_LEN_LO2 = 2'd2;   // 110 mod 4
  localparam logic [3:0] TRAILER_LEN = 4'd10;

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54; // T
      4'd1:    c = 8'h52; // R
      4'd2:    c = 8'h41; // A
      4'd3:    c = 8'h49; // I
      4'd4:    c = 8'h4c; // L
      4'd5:    c = 8'h45; // E
      4'd6:    c = 8'h52; // R
      4'd7:    c = 8'h21; // !
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // any non-hex character counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    return v;
  endfunction

  function automatic logic [31:0] sat_add_pad(input logic [31:0] n, input logic [1:0] p);
    logic [32:0] s;
    s = {1'b0, n} + 33'(p);
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  // name region: name padded so that header plus name end on a 4-byte boundary
  function automatic logic [31:0] pad_name(input logic [31:0] n);
    logic [1:0] p;
    p = 2'd0 - (HDR_LEN_LO2 + n[1:0]);
    return sat_add_pad(n, p);
  endfunction

  function automatic logic [31:0] pad_data(input logic [31:0] n);
    logic [1:0] p;
    p = 2'd0 - n[1:0];
    return sat_add_pad(n, p);
  endfunction

endpackage

// ===== hw/rtl/cpio_stream_if.sv =====
// ---------------------------------------------------------------------------
// cpio stream interfaces
// valid/ready channels for archive bytes in and walker results out
// ---------------------------------------------------------------------------
interface cpio_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink   (input valid, input archive_byte, output ready);
endinterface

interface cpio_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  cpio_pkg::kind_t     kind;

  modport source (output valid, output out_byte, output kind, input ready);
  modport sink   (input valid, input out_byte, input kind, output ready);
endinterface

// ===== hw/rtl/cpio_step.sv =====
// ---------------------------------------------------------------------------
// cpio_step
// per-byte walker state and result generation for one archive byte
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpio_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            byte_in,
  output cpio_pkg::step_res_t   res
);

  cpio_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] hex_acc_r, hex_acc_nxt;
  logic [31:0] name_size_r, name_size_nxt;
  logic [31:0] file_size_r, file_size_nxt;
  logic [31:0] region_r, region_nxt;
  logic [3:0]  trl_idx_r, trl_idx_nxt;
  logic        trl_match_r, trl_match_nxt;
  logic        path_ended_r, path_ended_nxt;

  logic [31:0] acc_shift;
  logic [31:0] rem_dec;
  logic        last;
  logic        done_now;
  logic        first_emit;
  logic        ee_emit;
  cpio_pkg::res_t first_res;

  assign acc_shift = {hex_acc_r[27:0], cpio_pkg::hex_value(byte_in)};
  assign rem_dec   = (region_r == 32'd0) ? 32'd0 : region_r - 32'd1;
  assign last      = (region_r <= 32'd1);

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hex_acc_nxt    = hex_acc_r;
    name_size_nxt  = name_size_r;
    file_size_nxt  = file_size_r;
    region_nxt     = region_r;
    trl_idx_nxt    = trl_idx_r;
    trl_match_nxt  = trl_match_r;
    path_ended_nxt = path_ended_r;
    done_now       = 1'b0;
    first_emit     = 1'b0;
    ee_emit        = 1'b0;
    first_res      = '{data: 8'd0, kind: cpio_pkg::K_PATH};

    unique case (phase_r)
      cpio_pkg::PH_HEADER: begin
        hex_acc_nxt = acc_shift;
        if (hdr_cnt_r == cpio_pkg::FSIZE_LAST) file_size_nxt = acc_shift;
        if (hdr_cnt_r == cpio_pkg::NSIZE_LAST) name_size_nxt = acc_shift;
        if (hdr_cnt_r >= cpio_pkg::HDR_LAST) begin
          region_nxt     = cpio_pkg::pad_name(name_size_r);
          phase_nxt      = cpio_pkg::PH_NAME;
          hdr_cnt_nxt    = 7'd0;
          path_ended_nxt = 1'b0;
          trl_idx_nxt    = 4'd0;
          trl_match_nxt  = 1'b1;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 7'd1;
        end
      end
      cpio_pkg::PH_NAME: begin
        region_nxt = rem_dec;
        if (!path_ended_r) begin
          first_emit = 1'b1;
          if (byte_in != 8'd0 && !last) begin
            first_res = '{data: byte_in, kind: cpio_pkg::K_PATH};
            if (trl_idx_r < cpio_pkg::TRAILER_LEN &&
                byte_in == cpio_pkg::trailer_char(trl_idx_r)) begin
              trl_idx_nxt = trl_idx_r + 4'd1;
            end else begin
              trl_match_nxt = 1'b0;
            end
          end else begin
            path_ended_nxt = 1'b1;
            if (trl_match_r && trl_idx_r == cpio_pkg::TRAILER_LEN) begin
              first_res = '{data: 8'd0, kind: cpio_pkg::K_ARCHIVE_END};
              phase_nxt = cpio_pkg::PH_DONE;
              done_now  = 1'b1;
            end else begin
              first_res = '{data: 8'd0, kind: cpio_pkg::K_PATH_END};
            end
          end
        end
        if (last && !done_now) begin
          region_nxt = cpio_pkg::pad_data(file_size_r);
          phase_nxt  = cpio_pkg::PH_DATA;
          // padded data size is zero only for an empty file
          if (file_size_r == 32'd0) begin
            ee_emit     = 1'b1;
            phase_nxt   = cpio_pkg::PH_HEADER;
            hdr_cnt_nxt = 7'd0;
            hex_acc_nxt = 32'd0;
          end
        end
      end
      cpio_pkg::PH_DATA: begin
        region_nxt = rem_dec;
        if (byte_in != 8'd0) begin
          first_emit = 1'b1;
          first_res  = '{data: byte_in, kind: cpio_pkg::K_DATA};
        end
        if (rem_dec == 32'd0) begin
          ee_emit     = 1'b1;
          phase_nxt   = cpio_pkg::PH_HEADER;
          hdr_cnt_nxt = 7'd0;
          hex_acc_nxt = 32'd0;
        end
      end
      cpio_pkg::PH_DONE: begin
      end
      default: begin
        phase_nxt = cpio_pkg::PH_HEADER;
      end
    endcase
  end

  // pack results: entry end takes the second slot when something came first
  always_comb begin
    res.v0 = step_en && (first_emit || ee_emit);
    res.v1 = step_en && first_emit && ee_emit;
    res.r0 = first_emit ? first_res : '{data: 8'd0, kind: cpio_pkg::K_ENTRY_END};
    res.r1 = '{data: 8'd0, kind: cpio_pkg::K_ENTRY_END};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= cpio_pkg::PH_HEADER;
      hdr_cnt_r    <= 7'd0;
      hex_acc_r    <= 32'd0;
      name_size_r  <= 32'd0;
      file_size_r  <= 32'd0;
      region_r     <= 32'd0;
      trl_idx_r    <= 4'd0;
      trl_match_r  <= 1'b1;
      path_ended_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      hex_acc_r    <= hex_acc_nxt;
      name_size_r  <= name_size_nxt;
      file_size_r  <= file_size_nxt;
      region_r     <= region_nxt;
      trl_idx_r    <= trl_idx_nxt;
      trl_match_r  <= trl_match_nxt;
      path_ended_r <= path_ended_nxt;
    end
  end

  `ASSERT_IMPL(a_done_silent, clk, rst_n, phase_r == cpio_pkg::PH_DONE, !res.v0)
  `ASSERT_IMPL(a_second_needs_first, clk, rst_n, res.v1, res.v0 && ee_emit)
  `ASSERT_IMPL(a_hdr_cnt_range, clk, rst_n, phase_r == cpio_pkg::PH_HEADER,
               hdr_cnt_r <= cpio_pkg::HDR_LAST)

endmodule

// ===== hw/rtl/cpio_out_fifo.sv =====
// ---------------------------------------------------------------------------
// cpio_out_fifo
// result queue, up to two writes and one read per cycle, drives the result channel
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpio_out_fifo #(
  parameter int DEPTH = 4  // power of two, at least 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpio_pkg::step_res_t  push,
  output cpio_pkg::fifo_stat_t stat,
  cpio_out_if.source           out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  cpio_pkg::res_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] push_n;
  logic          pop;

  assign pop        = out_ch.valid && out_ch.ready;
  assign push_n     = CW'(push.v0) + CW'(push.v1);
  assign wr_ptr_nxt = wr_ptr_r + AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + push_n - CW'(pop);

  assign stat.room2 = (count_r <= CW'(DEPTH - 2));
  assign stat.empty = (count_r == '0);

  assign out_ch.valid    = !stat.empty;
  assign out_ch.out_byte = mem_r[rd_ptr_r].data;
  assign out_ch.kind     = mem_r[rd_ptr_r].kind;

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_ptr_r] <= push.r0;
    if (push.v1) mem_r[wr_ptr_r + AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_IMPL(a_push_has_room, clk, rst_n, push.v0, stat.room2)

endmodule

// ===== hw/rtl/cpio_newc_archive_walker.sv =====
// ---------------------------------------------------------------------------
// cpio_newc_archive_walker
// walks a cpio newc archive byte by byte and emits path bytes, data bytes
// and entry / archive markers
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                    | transfer when
//  ---------+-----+----------------------------+----------------------
//  in_ch    | in  | archive_byte[7:0]          | valid && ready
//  out_ch   | out | out_byte[7:0], kind[2:0]   | valid && ready
//
//  one archive byte per cycle is taken while the queue has room for two
//  results, limited by the single-pass step logic behind the input register;
//  a byte's results are queued for out_ch when it leaves the input register
//  a byte yields at most two results (path end or data byte, plus entry
//  end), which leave the result queue one per cycle while out_ch is ready
//  in_ch stalls only while the byte in the input register waits for two free
//  queue entries; a stalled out_ch fills the queue and then backs up in_ch
//  synchronous active-low reset returns the walker to the first header byte
//  and empties the queue
//
`include "assert_macros.svh"

module cpio_newc_archive_walker #(
  parameter int FIFO_DEPTH = 4  // result queue entries, power of two >= 4
) (
  input  logic       clk,
  input  logic       rst_n,
  cpio_in_if.sink    in_ch,
  cpio_out_if.source out_ch
);

  // input register: holds one byte until the step logic can take it
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       fire;

  cpio_pkg::step_res_t  step_res;
  cpio_pkg::fifo_stat_t fifo_stat;

  // the step runs when the queue can absorb the worst case of two results
  assign fire        = in_valid_r && fifo_stat.room2;
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.archive_byte;
    end
  end

  // header counting, size fields, path and data emission
  cpio_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .byte_in (in_byte_r),
    .res     (step_res)
  );

  // results queue toward the consumer
  cpio_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (step_res),
    .stat   (fifo_stat),
    .out_ch (out_ch)
  );

  // a waiting byte that is not consumed stays in the input register
  `ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_r && !fire, in_valid_r)
  `ASSERT_IMPL(a_results_only_on_fire, clk, rst_n, step_res.v0, fire)

endmodule
